/* rtl/vmdl_pkg.sv */
// Shared constants, types and helpers for the varispeed multitap delay line.
package vmdl_pkg;

    // Ring geometry
    localparam int DEPTH     = 1024;
    localparam int AW        = $clog2(DEPTH);
    localparam int FILL_W    = AW + 1;
    localparam int NUM_TAPS  = 4;
    localparam int TAP_W     = 2;
    localparam int TAP_SEL_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    // Fixed point: positions are unsigned with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = AW + FRAC_BITS;
    localparam int SPEED_W   = 27;
    localparam int SAMPLE_W  = 32;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TAP0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TAP1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TAP2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TAP3 = 3'd3;
    localparam int REG_COUNT = 4;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Output queue depth
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    typedef logic [SAMPLE_W-1:0]       sample_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [AW-1:0]             addr_t;

    // Request from the tap logic to the sample ring
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t rd_addr;
    } ring_req_t;

    // One result transaction
    typedef struct packed {
        sample_t          data;
        logic [TAP_W-1:0] tap;
        logic             last;
    } out_item_t;

    // Clamp the speed to +/-(2^POS_W - 1) and reduce it modulo 2^POS_W
    function automatic pos_t speed_step(input speed_t s);
        logic signed [63:0] v;
        logic signed [63:0] lim;
        v   = 64'(s);
        lim = (64'sd1 <<< POS_W) - 64'sd1;
        if (v > lim)
        begin
            v = lim;
        end
        else if (v < -lim)
        begin
            v = -lim;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

/* rtl/vmdl_ring.sv */
// Sample ring: synchronous sample memory, write pointer and fill count.
module vmdl_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  vmdl_pkg::ring_req_t req,
    input  vmdl_pkg::sample_t   wr_data,
    output vmdl_pkg::sample_t   rd_data,
    output logic                rd_unwritten
);
    import vmdl_pkg::*;

    sample_t           mem [DEPTH];
    addr_t             wp_reg;
    addr_t             wp_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    sample_t           rd_data_reg;
    logic              rd_unwritten_reg;

    // Advance the write pointer and count filled entries up to DEPTH
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (req.wr_en)
        begin
            wp_next = wp_reg + addr_t'(1);
            if (fill_reg != FILL_W'(DEPTH))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    // Read port; rd_unwritten flags entries at or past the fill count, which were never written
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg      <= mem[req.rd_addr];
            rd_unwritten_reg <= ({1'b0, req.rd_addr} >= fill_reg);
        end
    end

    assign rd_data      = rd_data_reg;
    assign rd_unwritten = rd_unwritten_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("fill count beyond ring depth");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("read and write issued together");

    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> wp_reg == $past(wp_reg) + addr_t'(1))
        else $error("write pointer did not advance");

endmodule

/* rtl/varispeed_multitap_delay_line.sv */
// Top level of the varispeed multitap delay line: tap positions, config and output queue.
//
// Accepts one transaction per clock while in_stall is low, writes and reads mixed freely.
// A write stores sample_in at the write pointer and returns nothing; a read returns the
// sample at the integer part of the tap's Q10.16 position via the memory read register
// and the output queue, and advances the position by the tap's signed speed modulo the
// ring length. Throughput is set by the single-port sample memory: one access per cycle.
// A three-entry output queue absorbs the read in flight, so in_stall rises only when the
// queue plus the pending read would fill it, i.e. in the cycle after out_stall first
// holds back a result while reads arrive back to back. The ring reads as zero until
// written; a fill count tracks this, so no clearing pass runs after reset. Speed registers
// must be written through the cfg port only while idle; the block does not enforce this.
module varispeed_multitap_delay_line (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vmdl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  vmdl_pkg::speed_t                    cfg_data,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  vmdl_pkg::sample_t                   sample_in,
    input  logic [vmdl_pkg::TAP_W-1:0]          tap_index,
    input  logic                                block_last,
    // result transactions
    output logic                                out_valid,
    input  logic                                out_stall,
    output vmdl_pkg::sample_t                   sample_out,
    output logic [vmdl_pkg::TAP_W-1:0]          tap_echo,
    output logic                                last
);
    import vmdl_pkg::*;

    speed_t              speed_reg [REG_COUNT];
    pos_t                pos_reg [NUM_TAPS];
    logic                in_fire;
    logic                rd_fire;
    logic                tap_ok;
    logic [TAP_SEL_W-1:0] tap_sel;
    pos_t                cur_pos;
    pos_t                pos_next;
    ring_req_t           ring_req;
    sample_t             ring_rd_data;
    logic                ring_rd_unwritten;

    // read in flight
    logic                s1_valid_reg;
    logic                s1_force_zero_reg;
    logic [TAP_W-1:0]    s1_tap_reg;
    logic                s1_last_reg;

    // output queue
    out_item_t           oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_head_reg;
    logic [OQ_PTR_W-1:0] oq_tail_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic [OQ_CNT_W-1:0] oq_count_next;
    logic                oq_push;
    logic                oq_pop;
    out_item_t           oq_in;
    logic [OQ_CNT_W:0]   credits_used;

    // Config registers: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                speed_reg[i] <= speed_t'(1 << FRAC_BITS);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED_TAP0: speed_reg[0] <= cfg_data;
                REG_SPEED_TAP1: speed_reg[1] <= cfg_data;
                REG_SPEED_TAP2: speed_reg[2] <= cfg_data;
                REG_SPEED_TAP3: speed_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input while the queue and the pending read would fill it
    assign credits_used = {1'b0, oq_count_reg} + (OQ_CNT_W+1)'(s1_valid_reg);
    assign in_stall     = (credits_used >= (OQ_CNT_W+1)'(OQ_DEPTH));
    assign in_fire      = in_valid && !in_stall;
    assign rd_fire      = in_fire && (operation == OP_READ);

    // Select the tap and step its position
    assign tap_ok   = ({1'b0, tap_index} < (TAP_W+1)'(NUM_TAPS));
    assign tap_sel  = TAP_SEL_W'(tap_index);
    assign cur_pos  = pos_reg[tap_sel];
    assign pos_next = cur_pos + speed_step(speed_reg[tap_index]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (rd_fire && tap_ok)
        begin
            pos_reg[tap_sel] <= pos_next;
        end
    end

    // Issue the ring access
    always_comb
    begin
        ring_req.wr_en   = in_fire && (operation == OP_WRITE);
        ring_req.rd_en   = rd_fire && tap_ok;
        ring_req.rd_addr = cur_pos[POS_W-1:FRAC_BITS];
    end

    vmdl_ring u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (ring_req),
        .wr_data      (sample_in),
        .rd_data      (ring_rd_data),
        .rd_unwritten (ring_rd_unwritten)
    );

    // Track the read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            s1_force_zero_reg <= !tap_ok;
            s1_tap_reg        <= tap_index;
            s1_last_reg       <= block_last;
        end
    end

    // Push the finished read into the output queue
    always_comb
    begin
        oq_in.data = (s1_force_zero_reg || ring_rd_unwritten) ? '0 : ring_rd_data;
        oq_in.tap  = s1_tap_reg;
        oq_in.last = s1_last_reg;
    end

    assign oq_push = s1_valid_reg;
    assign oq_pop  = out_valid && !out_stall;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        priority if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + OQ_CNT_W'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (oq_push)
            begin
                oq_tail_reg <= (oq_tail_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_tail_reg + OQ_PTR_W'(1);
            end
            if (oq_pop)
            begin
                oq_head_reg <= (oq_head_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_head_reg + OQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_tail_reg] <= oq_in;
        end
    end

    // Present the queue head
    assign out_valid  = (oq_count_reg != '0);
    assign sample_out = oq_reg[oq_head_reg].data;
    assign tap_echo   = oq_reg[oq_head_reg].tap;
    assign last       = oq_reg[oq_head_reg].last;

    a_read_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |=> s1_valid_reg)
        else $error("accepted read did not reach the ring stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_WRITE) |=> !s1_valid_reg)
        else $error("write produced a result");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> (oq_count_reg < OQ_CNT_W'(OQ_DEPTH)) || oq_pop)
        else $error("output queue overflow");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue count out of range");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the varispeed multitap delay line: ring writes and tap reads.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vmdl_pkg::*;

    // Spare register indexes outside the speed map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint POS_MOD = longint'(DEPTH) << FRAC_BITS;
    localparam speed_t SPEED_UNITY = 27'sd65536;
    localparam speed_t SPEED_MAX = 27'sd67108863;
    localparam speed_t SPEED_MIN = 27'sh4000000;

    typedef struct {
        logic             op;
        sample_t          sample;
        logic [TAP_W-1:0] tap;
        logic             blast;
    } ring_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    speed_t               cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = OP_WRITE;
    sample_t              sample_in = '0;
    logic [TAP_W-1:0]     tap_index = '0;
    logic                 block_last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    sample_t              sample_out;
    logic [TAP_W-1:0]     tap_echo;
    logic                 last;

    // Stimulus and scoreboard
    ring_item_t  pending_items[$];
    out_item_t   expected_reads[$];
    ring_item_t  drive_item;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Shadow of the block's state
    sample_t     ring_model[DEPTH];
    int          model_wr_ptr;
    longint      model_pos[NUM_TAPS];
    speed_t      model_speed[REG_COUNT];

    varispeed_multitap_delay_line i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .sample_in  (sample_in),
        .tap_index  (tap_index),
        .block_last (block_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .tap_echo   (tap_echo),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted transaction to the shadow state; reads queue their sample
    task automatic advance_ring_model(input ring_item_t it);
        out_item_t res;
        longint    step;
        longint    lim;
        longint    p;
        if (it.op == OP_WRITE)
        begin
            ring_model[model_wr_ptr] = it.sample;
            model_wr_ptr = (model_wr_ptr == DEPTH - 1) ? 0 : model_wr_ptr + 1;
        end
        else
        begin
            res.tap = it.tap;
            res.last = it.blast;
            if (it.tap >= NUM_TAPS)
            begin
                res.data = '0;
            end
            else
            begin
                p = model_pos[it.tap];
                res.data = ring_model[p >> FRAC_BITS];
                // Saturate the speed to just under one full ring turn
                step = longint'(model_speed[it.tap]);
                lim = POS_MOD - 1;
                if (step > lim)
                begin
                    step = lim;
                end
                if (step < -lim)
                begin
                    step = -lim;
                end
                p = p + step;
                if (p >= POS_MOD)
                begin
                    p = p - POS_MOD;
                end
                if (p < 0)
                begin
                    p = p + POS_MOD;
                end
                model_pos[it.tap] = p;
            end
            expected_reads.push_back(res);
        end
    endtask

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // Driver: hold a stalled transaction, otherwise present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_ring_model(drive_item);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    operation <= drive_item.op;
                    sample_in <= drive_item.sample;
                    tap_index <= drive_item.tap;
                    block_last <= drive_item.blast;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expected read
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: sample %h tap %0d last %b",
                                           sample_out, tap_echo, last));
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (sample_out !== want.data || tap_echo !== want.tap
                        || last !== want.last)
                    begin
                        note_failure($sformatf(
                            "mismatch: expected sample %h tap %0d last %b, got %h %0d %b",
                            want.data, want.tap, want.last, sample_out, tap_echo, last));
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_item(input logic op, input sample_t smp,
                              input logic [TAP_W-1:0] tap, input logic blast);
        ring_item_t it;
        it.op = op;
        it.sample = smp;
        it.tap = tap;
        it.blast = blast;
        pending_items.push_back(it);
    endtask

    // Runs of same-kind transactions framed by block_last, with some broken framing
    task automatic queue_random_blocks(input int count);
        int               n;
        int               len;
        logic             op;
        logic [TAP_W-1:0] tap;
        logic             blast;
        n = 0;
        while (n < count)
        begin
            op = ($urandom_range(99) < 50) ? OP_READ : OP_WRITE;
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            tap = TAP_W'($urandom_range((1 << TAP_W) - 1));
            for (int k = 0; k < len; k++)
            begin
                blast = (k == len - 1);
                if ($urandom_range(9) == 0)
                begin
                    blast = 1'($urandom_range(1));
                end
                queue_item(op, $urandom,
                           ($urandom_range(7) == 0) ? TAP_W'($urandom_range((1 << TAP_W) - 1))
                                                    : tap,
                           blast);
            end
            n += len;
        end
    endtask

    // Wait until every transaction is in and every read is out, then let the pipe settle
    task automatic drain_pipeline();
        @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_reads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // One config transaction; the caller lowers cfg_valid after the last one
    task automatic write_speed_reg(input logic [CFG_IDX_W-1:0] idx, input speed_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx < REG_COUNT)
        begin
            model_speed[idx] = value;
        end
    endtask

    task automatic load_speeds(input speed_t s0, input speed_t s1, input speed_t s2,
                               input speed_t s3, input logic [CFG_IDX_W-1:0] spare_idx,
                               input speed_t spare_val);
        write_speed_reg(spare_idx, spare_val);
        write_speed_reg(REG_SPEED_TAP0, s0);
        write_speed_reg(REG_SPEED_TAP1, s1);
        write_speed_reg(REG_SPEED_TAP2, s2);
        write_speed_reg(REG_SPEED_TAP3, s3);
        cfg_valid <= 1'b0;
    endtask

    function automatic speed_t small_speed();
        return speed_t'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_model[i] = '0;
        end
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            model_pos[i] = 0;
        end
        for (int i = 0; i < REG_COUNT; i++)
        begin
            model_speed[i] = SPEED_UNITY;
        end
        model_wr_ptr = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reads of the unwritten ring, extreme words, writes with stray tap and last bits
        queue_item(OP_READ, '0, 2'd0, 1'b0);
        queue_item(OP_READ, '1, 2'd1, 1'b0);
        queue_item(OP_READ, '0, 2'd2, 1'b0);
        queue_item(OP_READ, '0, 2'd3, 1'b1);
        queue_item(OP_WRITE, 32'hFFFF_FFFF, 2'd3, 1'b1);
        queue_item(OP_WRITE, 32'h0000_0000, 2'd2, 1'b0);
        queue_item(OP_WRITE, 32'hAAAA_AAAA, 2'd1, 1'b1);
        queue_item(OP_WRITE, 32'h5555_5555, 2'd0, 1'b0);
        queue_item(OP_WRITE, 32'h8000_0001, 2'd3, 1'b0);
        queue_item(OP_WRITE, 32'h7FFF_FFFE, 2'd0, 1'b1);
        queue_item(OP_READ, '0, 2'd0, 1'b0);
        queue_item(OP_READ, '0, 2'd0, 1'b0);
        queue_item(OP_READ, '0, 2'd0, 1'b1);
        queue_item(OP_READ, '0, 2'd1, 1'b1);
        queue_item(OP_READ, '0, 2'd2, 1'b0);
        queue_item(OP_READ, '0, 2'd2, 1'b0);
        queue_item(OP_READ, '0, 2'd2, 1'b1);
        queue_item(OP_READ, '0, 2'd3, 1'b0);
        queue_item(OP_READ, '0, 2'd3, 1'b0);
        queue_item(OP_READ, '0, 2'd3, 1'b0);
        queue_item(OP_READ, '0, 2'd3, 1'b0);
        queue_item(OP_READ, '0, 2'd3, 1'b1);
        drain_pipeline();

        // Extreme speeds: full positive, most negative (saturates), standstill, unity
        load_speeds(SPEED_MAX, SPEED_MIN, '0, SPEED_UNITY, REG_SPARE_MID, SPEED_MAX);
        queue_random_blocks(430);
        drain_pipeline();

        // Reverse, half speed, fast forward, random; sender idles often
        send_idle_pct = 73;
        recv_stall_pct = 0;
        load_speeds(-SPEED_UNITY, 27'sd32768, 27'sd208953, speed_t'($urandom),
                    REG_SPARE_LO, speed_t'($urandom));
        queue_random_blocks(430);
        drain_pipeline();

        // Full-range random speeds; receiver stalls often
        send_idle_pct = 0;
        recv_stall_pct = 73;
        load_speeds(speed_t'($urandom), speed_t'($urandom), speed_t'($urandom),
                    speed_t'($urandom), REG_SPARE_HI, '1);
        queue_random_blocks(430);
        drain_pipeline();

        // Small random speeds within +/-4x unity; both sides pause
        send_idle_pct = 22;
        recv_stall_pct = 22;
        load_speeds(small_speed(), small_speed(), small_speed(), small_speed(),
                    REG_SPARE_MID, '0);
        queue_random_blocks(430);
        drain_pipeline();

        if (error_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
